// ===== hdl/vector_clock_race_detector_core_macros.svh =====
// assertion macros for the race detector
`ifndef VECTOR_CLOCK_RACE_DETECTOR_CORE_MACROS_SVH
`define VECTOR_CLOCK_RACE_DETECTOR_CORE_MACROS_SVH
`ifndef SYNTHESIS
`define VCRD_ASSERT_IMP(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |-> (cons)) \
    else $error(msg);
`define VCRD_ASSERT_NXT(lbl, ante, cons, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) (ante) |=> (cons)) \
    else $error(msg);
`else
`define VCRD_ASSERT_IMP(lbl, ante, cons, msg)
`define VCRD_ASSERT_NXT(lbl, ante, cons, msg)
`endif
`endif

// ===== hdl/vcrd_pkg.sv =====
`default_nettype none
package vcrd_pkg;
  localparam int unsigned THREADS   = 8;
  localparam int unsigned TW        = 3;
  localparam int unsigned LW        = 6;
  localparam int unsigned VW        = 10;
  localparam int unsigned CW        = 32;
  localparam int unsigned TA_W      = 2 * TW;
  localparam int unsigned LA_W      = LW + TW;
  localparam int unsigned VA_W      = VW + TW;

  typedef enum logic [2:0] {
    MODE_FORK    = 3'd0,
    MODE_JOIN    = 3'd1,
    MODE_ACQUIRE = 3'd2,
    MODE_RELEASE = 3'd3,
    MODE_READ    = 3'd4,
    MODE_WRITE   = 3'd5
  } mode_e;

  typedef enum logic [2:0] {
    S_CLEAR,
    S_IDLE,
    S_RD,
    S_EX,
    S_BUMP,
    S_REC,
    S_DONE
  } state_e;
endpackage
`default_nettype wire

// ===== hdl/vector_clock_race_detector_core.sv =====
// Race detector over slot-indexed vector clocks. Raise start while busy is
// low to hand over one event; result_valid_o pulses with race_free_o after
// the event is done, and the receiver cannot stall it.
// An event walks each thread's clock element in turn (sync events through
// one shared max/compare unit), with a memory read and update state per
// element; unknown modes go straight to the done state. After reset all
// 8192 entries of each variable clock memory are zeroed with busy high.
`default_nettype none
`include "vector_clock_race_detector_core_macros.svh"
module vector_clock_race_detector_core import vcrd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  output logic               busy,
  input  wire logic [2:0]    mode_i,
  input  wire logic [TW-1:0] thread_slot_i,
  input  wire logic [TW-1:0] peer_thread_slot_i,
  input  wire logic [LW-1:0] lock_slot_i,
  input  wire logic [VW-1:0] var_slot_i,
  output logic               result_valid_o,
  output logic               race_free_o
);
  logic [CW-1:0] thr_mem [2**TA_W];
  logic [CW-1:0] lck_mem [2**LA_W];
  logic [CW-1:0] rdc_mem [2**VA_W];
  logic [CW-1:0] wrc_mem [2**VA_W];

  logic [2**TA_W-1:0] thr_vld_q, thr_vld_d;
  logic [2**LW-1:0]   lck_vld_q, lck_vld_d;

  state_e state_q, state_d;
  logic [2:0]    mode_q, mode_d;
  logic [TW-1:0] t_q, t_d, p_q, p_d, idx_q, idx_d;
  logic [LW-1:0] l_q, l_d;
  logic [VW-1:0] v_q, v_d;
  logic [VA_W-1:0] clr_q, clr_d;
  logic [CW-1:0] own_q, own_d;
  logic fail_q, fail_d;
  logic res_vld_q, res_vld_d, res_q, res_d;

  logic [CW-1:0] ta_rd_q, tb_rd_q, lk_rd_q, rc_rd_q, wc_rd_q;
  logic [TW-1:0] row_a, row_b, own_row;
  logic [CW-1:0] ta_val, tb_val, lk_val, dst_val, src_val, merged;
  logic is_sync, bump_needed;

  logic          thr_we, lck_we, rdc_we, wrc_we;
  logic [TA_W-1:0] thr_wa;
  logic [VA_W-1:0] var_wa;
  logic [CW-1:0]   thr_wd, lck_wd, var_wd;

  always_comb begin
    row_a = t_q;
    row_b = t_q;
    case (mode_q)
      MODE_FORK: begin
        row_a = p_q;
        row_b = t_q;
      end
      MODE_JOIN: begin
        row_a = t_q;
        row_b = p_q;
      end
      default: begin
        row_a = t_q;
        row_b = t_q;
      end
    endcase
  end

  assign own_row     = (mode_q == MODE_JOIN) ? p_q : t_q;
  assign is_sync     = (mode_q == MODE_FORK) || (mode_q == MODE_JOIN) ||
                       (mode_q == MODE_ACQUIRE) || (mode_q == MODE_RELEASE);
  assign bump_needed = (mode_q == MODE_FORK) || (mode_q == MODE_JOIN) ||
                       (mode_q == MODE_RELEASE);

  // entries never written read as their reset value
  assign ta_val = thr_vld_q[{row_a, idx_q}] ? ta_rd_q : CW'(row_a == idx_q);
  assign tb_val = thr_vld_q[{row_b, idx_q}] ? tb_rd_q : CW'(row_b == idx_q);
  assign lk_val = lck_vld_q[l_q] ? lk_rd_q : '0;

  // shared max/compare unit
  assign dst_val = (mode_q == MODE_RELEASE) ? lk_val : ta_val;
  assign src_val = (mode_q == MODE_ACQUIRE) ? lk_val : tb_val;
  assign merged  = (dst_val < src_val) ? src_val : dst_val;

  always_ff @(posedge clk_i) begin
    ta_rd_q <= thr_mem[{row_a, idx_q}];
    tb_rd_q <= thr_mem[{row_b, idx_q}];
    lk_rd_q <= lck_mem[{l_q, idx_q}];
    rc_rd_q <= rdc_mem[{v_q, idx_q}];
    wc_rd_q <= wrc_mem[{v_q, idx_q}];
    if (thr_we) thr_mem[thr_wa] <= thr_wd;
    if (lck_we) lck_mem[{l_q, idx_q}] <= lck_wd;
    if (rdc_we) rdc_mem[var_wa] <= var_wd;
    if (wrc_we) wrc_mem[var_wa] <= var_wd;
  end

  always_comb begin
    state_d   = state_q;
    mode_d    = mode_q;
    t_d       = t_q;
    p_d       = p_q;
    l_d       = l_q;
    v_d       = v_q;
    idx_d     = idx_q;
    clr_d     = clr_q;
    own_d     = own_q;
    fail_d    = fail_q;
    res_vld_d = 1'b0;
    res_d     = res_q;
    thr_vld_d = thr_vld_q;
    lck_vld_d = lck_vld_q;
    case (state_q)
      S_CLEAR: begin
        clr_d = clr_q + 1'b1;
        if (clr_q == '1) state_d = S_IDLE;
      end
      S_IDLE: begin
        if (start) begin
          mode_d  = mode_i;
          t_d     = thread_slot_i;
          p_d     = peer_thread_slot_i;
          l_d     = lock_slot_i;
          v_d     = var_slot_i;
          idx_d   = '0;
          fail_d  = 1'b0;
          state_d = (mode_i > 3'(MODE_WRITE)) ? S_DONE : S_RD;
        end
      end
      S_RD: state_d = S_EX;
      S_EX: begin
        if (idx_q == own_row) own_d = tb_val;
        if (is_sync) begin
          if (mode_q == MODE_RELEASE) begin
            if (idx_q == TW'(THREADS - 1)) lck_vld_d[l_q] = 1'b1;
          end else begin
            thr_vld_d[{row_a, idx_q}] = 1'b1;
          end
        end else begin
          if (wc_rd_q > tb_val) fail_d = 1'b1;
          if ((mode_q == MODE_WRITE) && (rc_rd_q > tb_val)) fail_d = 1'b1;
        end
        idx_d = idx_q + 1'b1;
        if (idx_q == TW'(THREADS - 1)) begin
          if (bump_needed) state_d = S_BUMP;
          else if (is_sync || fail_d) state_d = S_DONE;
          else state_d = S_REC;
        end else begin
          state_d = S_RD;
        end
      end
      S_BUMP: begin
        thr_vld_d[{own_row, own_row}] = 1'b1;
        state_d = S_DONE;
      end
      S_REC: state_d = S_DONE;
      S_DONE: begin
        res_vld_d = 1'b1;
        res_d     = ~fail_q;
        state_d   = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

  always_comb begin
    thr_we = 1'b0;
    lck_we = 1'b0;
    rdc_we = 1'b0;
    wrc_we = 1'b0;
    thr_wa = {row_a, idx_q};
    thr_wd = merged;
    lck_wd = merged;
    var_wa = clr_q;
    var_wd = '0;
    case (state_q)
      S_CLEAR: begin
        rdc_we = 1'b1;
        wrc_we = 1'b1;
      end
      S_EX: begin
        thr_we = is_sync && (mode_q != MODE_RELEASE);
        lck_we = (mode_q == MODE_RELEASE);
      end
      S_BUMP: begin
        thr_we = 1'b1;
        thr_wa = {own_row, own_row};
        thr_wd = (own_q == '1) ? own_q : own_q + 1'b1;
      end
      S_REC: begin
        var_wa = {v_q, t_q};
        var_wd = own_q;
        rdc_we = (mode_q == MODE_READ);
        wrc_we = (mode_q == MODE_WRITE);
      end
      default: begin
        thr_we = 1'b0;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_CLEAR;
      clr_q     <= '0;
      res_vld_q <= 1'b0;
      thr_vld_q <= '0;
      lck_vld_q <= '0;
    end else begin
      state_q   <= state_d;
      clr_q     <= clr_d;
      res_vld_q <= res_vld_d;
      thr_vld_q <= thr_vld_d;
      lck_vld_q <= lck_vld_d;
    end
  end

  always_ff @(posedge clk_i) begin
    mode_q <= mode_d;
    t_q    <= t_d;
    p_q    <= p_d;
    l_q    <= l_d;
    v_q    <= v_d;
    idx_q  <= idx_d;
    own_q  <= own_d;
    fail_q <= fail_d;
    res_q  <= res_d;
  end

  assign busy           = (state_q != S_IDLE);
  assign result_valid_o = res_vld_q;
  assign race_free_o    = res_q;

  `VCRD_ASSERT_NXT(a_accept_busy, start && !busy, busy, "busy not raised after accept")
  `VCRD_ASSERT_NXT(a_single_strobe, result_valid_o, !result_valid_o, "result strobe too long")
  `VCRD_ASSERT_IMP(a_sync_free, result_valid_o && is_sync, race_free_o, "sync event flagged")
  `VCRD_ASSERT_IMP(a_strobe_idle, result_valid_o, !busy, "result while busy")
endmodule
`default_nettype wire

// ===== dv/vcrd_checker.sv =====
`timescale 1ns / 100ps
module vcrd_checker import vcrd_pkg::*; (
  input  wire logic          clk_i,
  input  wire logic          rst_ni,
  input  wire logic          start,
  input  wire logic          busy,
  input  wire logic [2:0]    mode_i,
  input  wire logic [TW-1:0] thread_slot_i,
  input  wire logic [TW-1:0] peer_thread_slot_i,
  input  wire logic [LW-1:0] lock_slot_i,
  input  wire logic [VW-1:0] var_slot_i,
  input  wire logic          result_valid_o,
  input  wire logic          race_free_o,
  output int                 fail_count_o,
  output int                 pending_o
);
  localparam int unsigned NUM_LOCKS = 1 << LW;
  localparam int unsigned NUM_VARS  = 1 << VW;
  localparam logic [CW-1:0] CLK_TOP = '1;

  logic [CW-1:0] thread_vc [THREADS][THREADS];
  logic [CW-1:0] lock_vc   [NUM_LOCKS][THREADS];
  logic [CW-1:0] read_vc   [NUM_VARS][THREADS];
  logic [CW-1:0] write_vc  [NUM_VARS][THREADS];
  bit            race_free_q [$];

  function automatic void bump_own(logic [TW-1:0] t);
    if (thread_vc[t][t] != CLK_TOP) thread_vc[t][t] = thread_vc[t][t] + 1'b1;
  endfunction

  function automatic bit apply_event(logic [2:0] mode, logic [TW-1:0] t, logic [TW-1:0] p,
                                     logic [LW-1:0] l, logic [VW-1:0] v);
    bit ok;
    ok = 1'b1;
    case (mode)
      MODE_FORK: begin
        for (int i = 0; i < THREADS; i++)
          if (thread_vc[p][i] < thread_vc[t][i]) thread_vc[p][i] = thread_vc[t][i];
        bump_own(t);
      end
      MODE_JOIN: begin
        for (int i = 0; i < THREADS; i++)
          if (thread_vc[t][i] < thread_vc[p][i]) thread_vc[t][i] = thread_vc[p][i];
        bump_own(p);
      end
      MODE_ACQUIRE: begin
        for (int i = 0; i < THREADS; i++)
          if (thread_vc[t][i] < lock_vc[l][i]) thread_vc[t][i] = lock_vc[l][i];
      end
      MODE_RELEASE: begin
        for (int i = 0; i < THREADS; i++)
          if (lock_vc[l][i] < thread_vc[t][i]) lock_vc[l][i] = thread_vc[t][i];
        bump_own(t);
      end
      MODE_READ, MODE_WRITE: begin
        for (int i = 0; i < THREADS; i++)
          if (write_vc[v][i] > thread_vc[t][i]) ok = 1'b0;
        if (mode == MODE_WRITE)
          for (int i = 0; i < THREADS; i++)
            if (read_vc[v][i] > thread_vc[t][i]) ok = 1'b0;
        if (ok) begin
          if (mode == MODE_READ) read_vc[v][t] = thread_vc[t][t];
          else write_vc[v][t] = thread_vc[t][t];
        end
      end
      default: ok = 1'b1;
    endcase
    return ok;
  endfunction

  assign pending_o = race_free_q.size();

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      fail_count_o <= 0;
      race_free_q.delete();
      for (int t = 0; t < THREADS; t++)
        for (int i = 0; i < THREADS; i++) thread_vc[t][i] = (t == i) ? 1 : 0;
      for (int l = 0; l < NUM_LOCKS; l++)
        for (int i = 0; i < THREADS; i++) lock_vc[l][i] = '0;
      for (int v = 0; v < NUM_VARS; v++)
        for (int i = 0; i < THREADS; i++) begin
          read_vc[v][i]  = '0;
          write_vc[v][i] = '0;
        end
    end else begin
      if (result_valid_o) begin
        if (race_free_q.size() == 0) begin
          $display("%0t: unexpected result: expected none, actual race_free %b",
                   $time, race_free_o);
          fail_count_o <= fail_count_o + 1;
        end else begin
          bit exp_rf;
          exp_rf = race_free_q.pop_front();
          if (race_free_o !== exp_rf) begin
            $display("%0t: race_free mismatch: expected %b, actual %b",
                     $time, exp_rf, race_free_o);
            fail_count_o <= fail_count_o + 1;
          end
        end
      end
      if (start && !busy)
        race_free_q.push_back(apply_event(mode_i, thread_slot_i, peer_thread_slot_i,
                                          lock_slot_i, var_slot_i));
    end
  end
endmodule

// ===== dv/testbench.sv =====
`timescale 1ns / 100ps
module testbench;
  import vcrd_pkg::*;

  localparam int WATCHDOG_LIMIT = 50000;

  logic          clk_i = 1'b0;
  logic          rst_ni = 1'b0;
  logic          start = 1'b0;
  logic          busy;
  logic [2:0]    mode_i = '0;
  logic [TW-1:0] thread_slot_i = '0;
  logic [TW-1:0] peer_thread_slot_i = '0;
  logic [LW-1:0] lock_slot_i = '0;
  logic [VW-1:0] var_slot_i = '0;
  logic          result_valid_o;
  logic          race_free_o;
  int            fail_count;
  int            pending;
  int            quiet_cycles = 0;
  int            items_sent = 0;
  bit            allow_gaps = 1'b1;

  vector_clock_race_detector_core u_top (.*);

  vcrd_checker u_checker (
    .clk_i, .rst_ni, .start, .busy, .mode_i, .thread_slot_i, .peer_thread_slot_i,
    .lock_slot_i, .var_slot_i, .result_valid_o, .race_free_o,
    .fail_count_o(fail_count), .pending_o(pending)
  );

  initial begin
    forever #5 clk_i = ~clk_i;
  end

  always @(posedge clk_i) begin
    if ((start && !busy) || result_valid_o) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("TEST FAILED");
      $finish;
    end
  end

  task automatic send_event(logic [2:0] mode, int t, int p, int l, int v);
    mode_i             <= mode;
    thread_slot_i      <= TW'(t);
    peer_thread_slot_i <= TW'(p);
    lock_slot_i        <= LW'(l);
    var_slot_i         <= VW'(v);
    start              <= 1'b1;
    @(posedge clk_i);
    while (busy) @(posedge clk_i);
    items_sent++;
    if (allow_gaps && $urandom_range(0, 3) == 0) begin
      start <= 1'b0;
      repeat ($urandom_range(1, 5)) @(posedge clk_i);
    end
  endtask

  task automatic locked_section();
    int t;
    int l;
    t = $urandom_range(0, THREADS - 1);
    l = $urandom_range(0, 3);
    send_event(MODE_ACQUIRE, t, $urandom, l, $urandom);
    repeat ($urandom_range(1, 3))
      send_event($urandom_range(0, 1) ? MODE_READ : MODE_WRITE, t, $urandom, $urandom,
                 $urandom_range(0, 7));
    send_event(MODE_RELEASE, t, $urandom, l, $urandom);
  endtask

  initial begin
    repeat (3) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // directed
    send_event(MODE_WRITE, 0, 0, 0, 5);
    send_event(MODE_READ, 1, 0, 0, 5);
    send_event(MODE_WRITE, 1, 0, 0, 5);
    send_event(MODE_RELEASE, 0, 0, 63, 0);
    send_event(MODE_ACQUIRE, 1, 0, 63, 0);
    send_event(MODE_WRITE, 1, 0, 0, 5);
    send_event(MODE_FORK, 7, 6, 0, 0);
    send_event(MODE_WRITE, 7, 0, 0, 1023);
    send_event(MODE_READ, 6, 0, 0, 1023);
    send_event(MODE_JOIN, 6, 7, 0, 0);
    send_event(MODE_READ, 6, 0, 0, 1023);
    send_event(MODE_FORK, 3, 3, 0, 0);
    send_event(MODE_JOIN, 4, 4, 0, 0);
    send_event(3'd6, 7, 7, 63, 1023);
    send_event(3'd7, 0, 0, 0, 0);
    send_event(MODE_READ, 2, 7, 63, 0);
    send_event(MODE_WRITE, 2, 7, 63, 0);
    send_event(MODE_WRITE, 3, 0, 0, 0);
    send_event(MODE_ACQUIRE, 0, 0, 0, 0);
    send_event(MODE_RELEASE, 7, 0, 0, 0);

    // random
    while (items_sent < 920) begin
      if (items_sent > 770) allow_gaps = 1'b0;
      case ($urandom_range(0, 9))
        0, 1, 2, 3: locked_section();
        4: send_event($urandom_range(0, 1) ? MODE_FORK : MODE_JOIN,
                      $urandom, $urandom, $urandom, $urandom);
        5, 6: send_event($urandom_range(0, 1) ? MODE_READ : MODE_WRITE,
                         $urandom, $urandom, $urandom, $urandom_range(0, 7));
        default: send_event(3'($urandom), $urandom, $urandom, $urandom, $urandom);
      endcase
    end
    start <= 1'b0;

    while (pending != 0) @(posedge clk_i);
    repeat (40) @(posedge clk_i);
    if (fail_count == 0) begin
      $display("TEST PASSED");
    end else begin
      $display("TEST FAILED");
    end
    $finish;
  end
endmodule

// ===== filelist.f =====
+incdir+hdl
hdl/vcrd_pkg.sv
hdl/vector_clock_race_detector_core.sv
dv/vcrd_checker.sv
dv/testbench.sv
